// ===== rtl/core/owle_pkg.sv =====
// Shared widths, operation codes and status codes of the ordered word list engine.
package owle_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int W_OP     = 3;
    localparam int W_POS    = 8;
    localparam int W_WORD   = 64;
    localparam int W_LEN    = 9;
    localparam int W_STATUS = 2;
    localparam int W_FIDX   = 8;

    localparam logic [W_OP-1:0] OP_APPEND            = 3'd0;
    localparam logic [W_OP-1:0] OP_SET_LENGTH        = 3'd1;
    localparam logic [W_OP-1:0] OP_REMOVE_AT         = 3'd2;
    localparam logic [W_OP-1:0] OP_SWAP_REMOVE_AT    = 3'd3;
    localparam logic [W_OP-1:0] OP_REMOVE_VALUE      = 3'd4;
    localparam logic [W_OP-1:0] OP_SWAP_REMOVE_VALUE = 3'd5;
    localparam logic [W_OP-1:0] OP_FIND              = 3'd6;
    localparam logic [W_OP-1:0] OP_READ              = 3'd7;

    localparam logic [W_STATUS-1:0] ST_OK   = 2'd0;
    localparam logic [W_STATUS-1:0] ST_MISS = 2'd1;
    localparam logic [W_STATUS-1:0] ST_FULL = 2'd2;

endpackage

// ===== rtl/core/owle_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module owle_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== rtl/core/ordered_word_list_engine.sv =====
// Top level of the ordered word list engine: list sequencer around one entry RAM.
//
// A request carries an operation, a position, a word and a new length on a
// valid/ready channel; every request yields exactly one result on a second
// valid/ready channel, in order. The entries live in one RAM with a single
// write port and a registered read port, so the sequencer walks the list one
// entry per cycle.
// Steps per request: append, a shrinking set length and every rejected
// request go straight to the result; a read fetches the entry first. A
// removal at an index fetches the entry, then an ordered removal shifts each
// later entry down by one and a swap removal copies the last entry into the
// gap unless the entry is itself the last. A search inspects the entries in
// order; a removal by value then shifts or swaps as above. A growing set
// length clears each new slot in turn.
// One request is worked on at a time; the next one is accepted as soon as
// the previous result sits in the output register.
// Reset empties the list at once; there is no clearing pass, as a slot is
// always written before it can be read. A stalled receiver holds the result
// and the sequencer waits with the next result until the output is free.
module ordered_word_list_engine #(
    parameter int CAPACITY = owle_pkg::CAPACITY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  logic [owle_pkg::W_OP-1:0]      i_op,
    input  logic [owle_pkg::W_POS-1:0]     i_position,
    input  logic [owle_pkg::W_WORD-1:0]    i_word_value,
    input  logic [owle_pkg::W_LEN-1:0]     i_new_length,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output logic [owle_pkg::W_STATUS-1:0]  o_status,
    output logic [owle_pkg::W_FIDX-1:0]    o_found_index,
    output logic [owle_pkg::W_WORD-1:0]    o_entry_word,
    output logic [owle_pkg::W_LEN-1:0]     o_length_now
);

    import owle_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > W_LEN) ? CW : W_LEN;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FETCH  = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_SWAP   = 3'd4;
    localparam logic [2:0] S_FILL   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [W_OP-1:0]     r_op, n_op;
    logic [W_WORD-1:0]   r_val, n_val;
    logic [AW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_end, n_end;
    logic [W_STATUS-1:0] r_status, n_status;
    logic [AW-1:0]       r_fidx, n_fidx;
    logic [W_WORD-1:0]   r_word, n_word;
    logic                r_o_valid, n_o_valid;
    logic [W_STATUS-1:0] r_o_status, n_o_status;
    logic [W_FIDX-1:0]   r_o_fidx, n_o_fidx;
    logic [W_WORD-1:0]   r_o_word, n_o_word;
    logic [W_LEN-1:0]    r_o_len, n_o_len;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [W_WORD-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [W_WORD-1:0]   ram_rdata;

    logic                take_go;
    logic [CW-1:0]       last;
    logic                out_free;

    owle_ram #(
        .WIDTH(W_WORD),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign last        = r_cnt - CW'(1);
    assign out_free    = !r_o_valid || i_res_ready;
    assign o_req_ready = i_rst_n && (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_op       = r_op;
        n_val      = r_val;
        n_idx      = r_idx;
        n_end      = r_end;
        n_status   = r_status;
        n_fidx     = r_fidx;
        n_word     = r_word;
        n_o_valid  = r_o_valid && !i_res_ready;
        n_o_status = r_o_status;
        n_o_fidx   = r_o_fidx;
        n_o_word   = r_o_word;
        n_o_len    = r_o_len;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = '0;
        ram_raddr  = r_idx;
        take_go    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid && o_req_ready) begin
                    n_op     = i_op;
                    n_val    = i_word_value;
                    n_status = ST_OK;
                    n_fidx   = '0;
                    n_word   = '0;
                    n_state  = S_DONE;
                    case (i_op)
                        OP_APPEND: begin
                            if (XW'(r_cnt) >= XW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_cnt);
                                ram_wdata = i_word_value;
                                n_cnt     = r_cnt + CW'(1);
                            end
                        end
                        OP_SET_LENGTH: begin
                            if (XW'(i_new_length) > XW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (XW'(i_new_length) > XW'(r_cnt)) begin
                                n_idx   = AW'(r_cnt);
                                n_end   = CW'(i_new_length);
                                n_state = S_FILL;
                            end else begin
                                n_cnt = CW'(i_new_length);
                            end
                        end
                        OP_REMOVE_AT, OP_SWAP_REMOVE_AT, OP_READ: begin
                            if (XW'(i_position) >= XW'(r_cnt)) begin
                                n_status = ST_MISS;
                            end else begin
                                ram_raddr = AW'(i_position);
                                n_idx     = AW'(i_position);
                                n_state   = S_FETCH;
                            end
                        end
                        default: begin
                            if (r_cnt == '0) begin
                                n_status = ST_MISS;
                            end else begin
                                ram_raddr = '0;
                                n_idx     = '0;
                                n_state   = S_SEARCH;
                            end
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_word = ram_rdata;
                if (r_op == OP_READ) begin
                    n_state = S_DONE;
                end else begin
                    take_go = 1'b1;
                end
            end
            S_SEARCH: begin
                if (ram_rdata == r_val) begin
                    n_fidx = r_idx;
                    if (r_op == OP_FIND) begin
                        n_state = S_DONE;
                    end else begin
                        n_word  = ram_rdata;
                        take_go = 1'b1;
                    end
                end else if (CW'(r_idx) + CW'(1) == r_cnt) begin
                    n_status = ST_MISS;
                    n_state  = S_DONE;
                end else begin
                    ram_raddr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end
            end
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                if (CW'(r_idx) + CW'(1) == last) begin
                    n_cnt   = last;
                    n_state = S_DONE;
                end else begin
                    ram_raddr = r_idx + AW'(2);
                    n_idx     = r_idx + AW'(1);
                end
            end
            S_SWAP: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                n_cnt     = last;
                n_state   = S_DONE;
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = '0;
                if (CW'(r_idx) + CW'(1) == r_end) begin
                    n_cnt   = r_end;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_fidx   = W_FIDX'(r_fidx);
                    n_o_word   = r_word;
                    n_o_len    = W_LEN'(r_cnt);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (take_go) begin
            if (CW'(r_idx) == last) begin
                n_cnt   = last;
                n_state = S_DONE;
            end else if (r_op == OP_REMOVE_AT || r_op == OP_REMOVE_VALUE) begin
                ram_raddr = r_idx + AW'(1);
                n_state   = S_SHIFT;
            end else begin
                ram_raddr = AW'(last);
                n_state   = S_SWAP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_end      <= n_end;
        r_status   <= n_status;
        r_fidx     <= n_fidx;
        r_word     <= n_word;
        r_o_status <= n_o_status;
        r_o_fidx   <= n_o_fidx;
        r_o_word   <= n_o_word;
        r_o_len    <= n_o_len;
    end

    assign o_res_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_found_index = r_o_fidx;
    assign o_entry_word  = r_o_word;
    assign o_length_now  = r_o_len;

endmodule

// ===== rtl/core/owle_checker.sv =====
// Port-level assertions for the ordered word list engine and their binding.
module owle_checker #(
    parameter int CAPACITY = owle_pkg::CAPACITY_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_res_valid,
    input logic                           i_res_ready,
    input logic [owle_pkg::W_STATUS-1:0]  o_status,
    input logic [owle_pkg::W_FIDX-1:0]    o_found_index,
    input logic [owle_pkg::W_WORD-1:0]    o_entry_word,
    input logic [owle_pkg::W_LEN-1:0]     o_length_now
);

    import owle_pkg::*;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_status == ST_OK || o_status == ST_MISS || o_status == ST_FULL))
        else $error("result carries an undefined status code");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status != ST_OK) |-> (o_entry_word == '0 && o_found_index == '0))
        else $error("failed request returned a word or an index");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (32'(o_length_now) <= 32'(CAPACITY)))
        else $error("reported length exceeds the capacity");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_entry_word)
                                          && $stable(o_length_now)))
        else $error("stalled result changed");

endmodule

bind ordered_word_list_engine owle_checker #(.CAPACITY(CAPACITY)) u_owle_checker (.*);
